[src/rqsi_pkg.sv]
// rqsi_pkg: shared types and codes for the ready queue with sorted insertion
// no dependencies; used by the queue cell, the top level and the bench
package rqsi_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 16;

	localparam logic [1:0] MODE_FCFS = 2'd0;
	localparam logic [1:0] MODE_PRIO = 2'd1;
	localparam logic [1:0] MODE_SJF  = 2'd2;

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam int OCC_W = 5;

	typedef struct packed {
		logic [15:0] run_time;
		logic [7:0]  priority_req;
		logic [7:0]  task_id;
	} task_t;

	typedef struct packed {
		logic       enq;
		logic       deq;
		logic [1:0] mode;
	} cell_ctrl_t;

endpackage

[src/rqsi_req_if.sv]
// rqsi_req_if: request channel (enqueue or dequeue beat) with valid/ready
// no dependencies
interface rqsi_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [7:0]  task_id;
	logic [7:0]  priority_req;
	logic [15:0] run_time;

	modport source (output valid, func, task_id, priority_req, run_time, input ready);
	modport sink   (input valid, func, task_id, priority_req, run_time, output ready);
endinterface

[src/rqsi_rsp_if.sv]
// rqsi_rsp_if: response channel (status, dequeued task, occupancy) with valid/ready
// no dependencies
interface rqsi_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  out_id;
	logic [7:0]  out_priority;
	logic [15:0] out_run_time;
	logic [4:0]  occupancy;

	modport source (output valid, status, out_id, out_priority, out_run_time, occupancy,
		input ready);
	modport sink   (input valid, status, out_id, out_priority, out_run_time, occupancy,
		output ready);
endinterface

[src/rqsi_cell.sv]
// rqsi_cell: one slot of the queue; compares its key, shifts left or right
// depends on rqsi_pkg
module rqsi_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  logic               clk,
	input  rqsi_pkg::cell_ctrl_t ctrl,
	input  logic [CNT_W-1:0]   count,
	input  rqsi_pkg::task_t    new_entry,
	input  rqsi_pkg::task_t    left_entry,
	input  rqsi_pkg::task_t    right_entry,
	input  logic               taken_in,
	output logic               taken_out,
	output rqsi_pkg::task_t    entry
);
	import rqsi_pkg::*;

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

	task_t entry_q;
	logic  occupied;
	logic  key_le;
	logic  hit;

	assign occupied = IDX_C < count;

	always_comb begin
		case (ctrl.mode)
			MODE_PRIO: key_le = new_entry.priority_req <= entry_q.priority_req;
			MODE_SJF:  key_le = new_entry.run_time <= entry_q.run_time;
			default:   key_le = 1'b0;
		endcase
	end

	assign hit       = !occupied || key_le;
	assign taken_out = taken_in || hit;
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.deq) begin
			entry_q <= right_entry;
		end else if (ctrl.enq) begin
			if (taken_in) begin
				entry_q <= left_entry;
			end else if (hit) begin
				entry_q <= new_entry;
			end
		end
	end

endmodule

[src/ready_queue_sorted_insert.sv]
// ready_queue_sorted_insert: bounded task queue, fcfs / priority / shortest-job insert
// depends on rqsi_pkg, rqsi_req_if, rqsi_rsp_if and rqsi_cell
//
//  channel | dir | beat
//  req     | in  | func, task_id, priority_req, run_time
//  rsp     | out | status, out_id, out_priority, out_run_time, occupancy
//  cfg     | in  | cfg_we, cfg_wdata (queue_mode)
//
// one request per cycle unless rsp stalls; its response is valid in the next cycle
// the cell row inserts or shifts all slots together, position found by a prefix chain
// req.ready is low only while a response waits on a stalled rsp channel
// reset clears the fill count, mode and response valid; slot contents are not reset
module ready_queue_sorted_insert #(
	parameter int QUEUE_DEPTH = rqsi_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	rqsi_req_if.sink   req,
	rqsi_rsp_if.source rsp,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata
);
	import rqsi_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

	logic [1:0]       mode_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             rsp_valid_q;
	logic [1:0]       status_q;
	task_t            head_q;
	logic [OCC_W-1:0] occ_q;

	logic       accept;
	logic       is_full;
	logic       is_empty;
	cell_ctrl_t ctrl;
	task_t      new_entry;
	task_t      entries [QUEUE_DEPTH];
	logic       taken [QUEUE_DEPTH+1];
	logic [1:0] status_nxt;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_full   = count_q == DEPTH_C;
	assign is_empty  = count_q == '0;

	assign new_entry = '{run_time: req.run_time, priority_req: req.priority_req,
		task_id: req.task_id};

	assign ctrl.enq  = accept && req.func == FUNC_ENQ && !is_full;
	assign ctrl.deq  = accept && req.func == FUNC_DEQ && !is_empty;
	assign ctrl.mode = mode_q;

	assign taken[0] = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		rqsi_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.count       (count_q),
			.new_entry   (new_entry),
			.left_entry  ((i == 0) ? new_entry : entries[(i == 0) ? 0 : i-1]),
			.right_entry ((i == QUEUE_DEPTH-1) ? entries[i]
				: entries[(i == QUEUE_DEPTH-1) ? i : i+1]),
			.taken_in    (taken[i]),
			.taken_out   (taken[i+1]),
			.entry       (entries[i])
		);
	end

	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_DONE;
		if (ctrl.enq) begin
			count_nxt = count_q + 1'b1;
		end else if (ctrl.deq) begin
			count_nxt = count_q - 1'b1;
		end
		if (req.func == FUNC_DEQ && is_empty) begin
			status_nxt = ST_EMPTY;
		end else if (req.func == FUNC_ENQ && is_full) begin
			status_nxt = ST_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_FCFS;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
			head_q   <= ctrl.deq ? entries[0] : '0;
			occ_q    <= OCC_W'(count_nxt);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.out_id       = head_q.task_id;
	assign rsp.out_priority = head_q.priority_req;
	assign rsp.out_run_time = head_q.run_time;
	assign rsp.occupancy    = occ_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("fill count above depth");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("fill count moved without a request");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp.valid)
		else $error("accepted request produced no response");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("request taken while response stalled");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: self-checking bench for ready_queue_sorted_insert, with a shadow task queue
// depends on rqsi_pkg, rqsi_req_if, rqsi_rsp_if and the ready_queue_sorted_insert RTL
module tb_top;
	import rqsi_pkg::*;

	localparam int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int HOLD_OFF_CYCLES = 64;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_BEATS = 75;

	typedef struct packed {
		logic [1:0] status;
		task_t      popped;
		logic [4:0] occupancy;
	} response_t;

	class ready_queue_shadow;
		task_t       held[$];
		response_t   awaited[$];
		logic [1:0]  mode;
		int unsigned mismatches;
		int unsigned beats_in;
		int unsigned empty_deqs;
		int unsigned full_drops;

		function new();
			mode = MODE_FCFS;
			mismatches = 0;
			beats_in = 0;
			empty_deqs = 0;
			full_drops = 0;
		endfunction

		function void set_mode(logic [1:0] m);
			mode = m;
		endfunction

		function logic [15:0] sort_key(task_t t);
			return (mode == MODE_PRIO) ? {8'h00, t.priority_req} : t.run_time;
		endfunction

		function void note_request(logic func, task_t t);
			response_t r;
			int        pos;
			r = '0;
			beats_in++;
			if (func == FUNC_DEQ) begin
				if (held.size() == 0) begin
					r.status = ST_EMPTY;
					empty_deqs++;
				end else begin
					r.status = ST_DONE;
					r.popped = held.pop_front();
				end
			end else if (held.size() >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
				full_drops++;
			end else begin
				pos = held.size();
				if (mode == MODE_PRIO || mode == MODE_SJF) begin
					for (int i = 0; i < held.size(); i++) begin
						if (sort_key(t) <= sort_key(held[i])) begin
							pos = i;
							break;
						end
					end
				end
				held.insert(pos, t);
				r.status = ST_DONE;
			end
			r.occupancy = 5'(held.size());
			awaited.push_back(r);
		endfunction

		function void check_response(logic [1:0] status, logic [7:0] id, logic [7:0] prio,
			logic [15:0] wt, logic [4:0] occ);
			response_t r;
			if (awaited.size() == 0) begin
				$error("response beat with nothing expected");
				mismatches++;
				return;
			end
			r = awaited.pop_front();
			if (status !== r.status) begin
				$error("status: expected %0d, got %0d", r.status, status);
				mismatches++;
			end
			if (id !== r.popped.task_id) begin
				$error("out_id: expected %0d, got %0d", r.popped.task_id, id);
				mismatches++;
			end
			if (prio !== r.popped.priority_req) begin
				$error("out_priority: expected %0d, got %0d", r.popped.priority_req, prio);
				mismatches++;
			end
			if (wt !== r.popped.run_time) begin
				$error("out_run_time: expected %0d, got %0d", r.popped.run_time, wt);
				mismatches++;
			end
			if (occ !== r.occupancy) begin
				$error("occupancy: expected %0d, got %0d", r.occupancy, occ);
				mismatches++;
			end
		endfunction

		function int unsigned outstanding();
			return awaited.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_wdata;

	rqsi_req_if req_ch ();
	rqsi_rsp_if rsp_ch ();

	ready_queue_shadow shadow = new();

	bit          hold_off_request = 1'b0;
	int unsigned burst_left = 0;
	int unsigned mode_writes = 0;
	int unsigned quiet_cycles = 0;

	ready_queue_sorted_insert #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				shadow.note_request(req_ch.func, {req_ch.run_time, req_ch.priority_req,
					req_ch.task_id});
			if (rsp_ch.valid && rsp_ch.ready)
				shadow.check_response(rsp_ch.status, rsp_ch.out_id, rsp_ch.out_priority,
					rsp_ch.out_run_time, rsp_ch.occupancy);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int unsigned tick;
		tick = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
			end else begin
				case ((tick / 150) % 4)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 99) >= 30);
					2: rsp_ch.ready <= ($urandom_range(0, 99) >= 75);
					default: rsp_ch.ready <= (tick % 3 == 0);
				endcase
				tick++;
			end
		end
	end

	function automatic task_t make_task(int id, int prio, int wt);
		task_t t;
		t.task_id = 8'(id);
		t.priority_req = 8'(prio);
		t.run_time = 16'(wt);
		return t;
	endfunction

	function automatic logic [15:0] draw_key(logic [15:0] top);
		case ($urandom_range(0, 3))
			0, 1: return 16'($urandom_range(0, 3));
			2: return $urandom_range(0, 1) ? top : 16'd0;
			default: return 16'($urandom_range(0, top));
		endcase
	endfunction

	function automatic task_t draw_task();
		return make_task($urandom_range(0, 255), draw_key(16'h00FF), draw_key(16'hFFFF));
	endfunction

	task automatic send_beat(logic func, task_t t);
		req_ch.valid <= 1'b1;
		req_ch.func <= func;
		req_ch.task_id <= t.task_id;
		req_ch.priority_req <= t.priority_req;
		req_ch.run_time <= t.run_time;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic idle_cycles(int unsigned n);
		if (n > 0) begin
			req_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic paced_beat(logic func, task_t t, bit no_gaps);
		if (burst_left == 0) begin
			if (!no_gaps)
				idle_cycles($urandom_range(1, 8));
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		send_beat(func, t);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (shadow.outstanding() != 0);
	endtask

	task automatic write_mode(logic [1:0] m);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow.set_mode(m);
		mode_writes++;
	endtask

	initial begin
		logic [1:0]  phase_modes [8];
		int unsigned deq_pct;
		phase_modes = '{MODE_PRIO, MODE_SJF, MODE_SPARE, MODE_FCFS,
			MODE_SJF, MODE_PRIO, MODE_FCFS, MODE_SPARE};
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= MODE_FCFS;
		req_ch.valid <= 1'b0;
		req_ch.func <= FUNC_ENQ;
		req_ch.task_id <= '0;
		req_ch.priority_req <= '0;
		req_ch.run_time <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fcfs after reset: empty pop, field extremes, fill up, drop on full
		paced_beat(FUNC_DEQ, make_task(0, 0, 0), 1'b0);
		paced_beat(FUNC_ENQ, make_task(0, 0, 0), 1'b0);
		paced_beat(FUNC_ENQ, make_task(255, 255, 65535), 1'b0);
		for (int i = 2; i < QUEUE_DEPTH; i++)
			paced_beat(FUNC_ENQ, make_task(i, i * 17, i * 4099), 1'b0);
		paced_beat(FUNC_ENQ, make_task(8'h5A, 1, 1), 1'b0);
		paced_beat(FUNC_DEQ, make_task(0, 0, 0), 1'b0);
		paced_beat(FUNC_DEQ, make_task(0, 0, 0), 1'b0);

		// sorted inserts into a queue filled in arrival order, ties go ahead
		write_mode(MODE_PRIO);
		paced_beat(FUNC_ENQ, make_task(8'hA0, 3 * 17, 7), 1'b0);
		paced_beat(FUNC_ENQ, make_task(8'hA1, 0, 9), 1'b0);
		write_mode(MODE_SJF);
		paced_beat(FUNC_DEQ, make_task(0, 0, 0), 1'b0);
		paced_beat(FUNC_ENQ, make_task(8'hA2, 200, 65535), 1'b0);
		paced_beat(FUNC_ENQ, make_task(8'hA3, 100, 0), 1'b0);

		for (int p = 0; p < 8; p++) begin
			write_mode(phase_modes[p]);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (p == 1 && n == 20)
					hold_off_request = 1'b1;
				if (p == 3 && n == 40)
					wait_drained();
				deq_pct = (n < 30) ? 20 : (n < 50) ? 50 : 85;
				paced_beat(($urandom_range(0, 99) < deq_pct) ? FUNC_DEQ : FUNC_ENQ,
					draw_task(), (p % 3) == 0);
			end
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (shadow.outstanding() != 0)
			$error("%0d expected responses never arrived", shadow.outstanding());
		$display("covered %0d request beats over %0d mode writes, fcfs/priority/sjf/spare",
			shadow.beats_in, mode_writes);
		$display("saw %0d pops of an empty queue and %0d pushes dropped on a full queue",
			shadow.empty_deqs, shadow.full_drops);
		if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[sim.f]
src/rqsi_pkg.sv
src/rqsi_req_if.sv
src/rqsi_rsp_if.sv
src/rqsi_cell.sv
src/ready_queue_sorted_insert.sv
tb/tb_top.sv
